/* design/tcr_pkg.sv */
// Shared command codes and handshake types of the triangle coverage rasterizer.
`default_nettype none
package tcr_pkg;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic valid;
        logic is_load;
    } t_cmd_ctl;

endpackage
`default_nettype wire

/* design/tcr_front.sv */
// Front end: accepts input words into a two-entry queue and classifies them as load or step.
`default_nettype none
module tcr_front
    import tcr_pkg::*;
#(
    parameter int C   = 12,
    parameter int COL = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_action,
    input  wire logic [6*C-1:0]   i_vert,
    input  wire logic [COL-1:0]   i_color,
    output t_cmd_ctl              o_ctl,
    input  wire logic             i_cmd_ready,
    output logic      [6*C-1:0]   o_vert,
    output logic      [COL-1:0]   o_color
);

    localparam int WW = 1 + 6*C + COL;

    logic [WW-1:0] r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;
    logic          push;
    logic          pop;
    logic [WW-1:0] head;

    assign o_ready       = (r_count != 2'd2);
    assign push          = i_valid && o_ready;
    assign pop           = o_ctl.valid && i_cmd_ready;
    assign head          = r_mem[r_rd];
    assign o_ctl.valid   = (r_count != 2'd0);
    assign o_ctl.is_load = (head[0] == ACT_LOAD);
    assign o_vert        = head[6*C:1];
    assign o_color       = head[WW-1:6*C+1];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= {i_color, i_vert, i_action};
        end
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |=> (r_count <= 2'd1))
        else $error("queue grew by more than one word");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !pop) |=> (r_count == 2'd2))
        else $error("full queue changed without a pop");

endmodule
`default_nettype wire

/* design/tcr_back.sv */
// Back end: triangle setup, incremental edge stepping and the registered pixel output.
`default_nettype none
module tcr_back
    import tcr_pkg::*;
#(
    parameter int C   = 12,
    parameter int COL = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd_ctl         i_ctl,
    output logic                  o_cmd_ready,
    input  wire logic [6*C-1:0]   i_vert,
    input  wire logic [COL-1:0]   i_color,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic signed [C-1:0]   o_x,
    output logic signed [C-1:0]   o_y,
    output logic                  o_covered,
    output logic      [COL-1:0]   o_color,
    output logic                  o_last
);

    localparam int D = C + 1;
    localparam int P = 2*C + 2;
    localparam int E = 2*C + 3;
    localparam int EA [3] = '{1, 2, 0};
    localparam int EB [3] = '{2, 0, 1};

    typedef enum logic [1:0] {S_SCAN, S_MUL, S_SUM} t_state;

    t_state                r_state;
    logic                  r_active;
    logic signed [C-1:0]   r_vx [3];
    logic signed [C-1:0]   r_vy [3];
    logic      [COL-1:0]   r_color;
    logic signed [C-1:0]   r_minx;
    logic signed [C-1:0]   r_miny;
    logic signed [C-1:0]   r_maxx;
    logic signed [C-1:0]   r_maxy;
    logic signed [C-1:0]   r_px;
    logic signed [C-1:0]   r_py;
    logic signed [P-1:0]   r_p0 [3];
    logic signed [P-1:0]   r_p1 [3];
    logic signed [D-1:0]   r_dx [3];
    logic signed [D-1:0]   r_dy [3];
    logic signed [E-1:0]   r_w [3];
    logic signed [E-1:0]   r_wrow [3];
    logic                  r_ovalid;
    logic signed [C-1:0]   r_ox;
    logic signed [C-1:0]   r_oy;
    logic                  r_ocov;
    logic      [COL-1:0]   r_ocolor;
    logic                  r_olast;

    logic signed [C-1:0]   in_x [3];
    logic signed [C-1:0]   in_y [3];
    logic signed [D-1:0]   ka [3];
    logic signed [D-1:0]   kb [3];
    logic signed [D-1:0]   dya [3];
    logic signed [D-1:0]   dxa [3];
    logic [2:0]            w_pos;
    logic [2:0]            w_neg;
    logic                  out_free;
    logic                  pop;
    logic                  pop_step;
    logic                  last;
    logic                  covered;

    function automatic logic signed [C-1:0] min3(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b,
                                                 input logic signed [C-1:0] c);
        logic signed [C-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [C-1:0] max3(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b,
                                                 input logic signed [C-1:0] c);
        logic signed [C-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    for (genvar k = 0; k < 3; k++) begin : g_edge
        assign in_x[k]  = i_vert[2*k*C +: C];
        assign in_y[k]  = i_vert[(2*k+1)*C +: C];
        assign ka[k]    = D'(r_minx) - D'(r_vx[EA[k]]);
        assign kb[k]    = D'(r_miny) - D'(r_vy[EA[k]]);
        assign dya[k]   = D'(r_vy[EB[k]]) - D'(r_vy[EA[k]]);
        assign dxa[k]   = D'(r_vx[EB[k]]) - D'(r_vx[EA[k]]);
        assign w_pos[k] = !r_w[k][E-1];
        assign w_neg[k] = r_w[k][E-1] || (r_w[k] == '0);
    end

    assign covered     = (&w_pos) || (&w_neg);
    assign last        = (r_px == r_maxx) && (r_py == r_maxy);
    assign out_free    = !r_ovalid || i_ready;
    assign o_cmd_ready = (r_state == S_SCAN) && (i_ctl.is_load || !r_active || out_free);
    assign pop         = i_ctl.valid && o_cmd_ready;
    assign pop_step    = pop && !i_ctl.is_load && r_active;

    assign o_valid   = r_ovalid;
    assign o_x       = r_ox;
    assign o_y       = r_oy;
    assign o_covered = r_ocov;
    assign o_color   = r_ocolor;
    assign o_last    = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SCAN;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && !pop_step) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_SCAN: begin
                    if (pop && i_ctl.is_load) begin
                        for (int k = 0; k < 3; k++) begin
                            r_vx[k] <= in_x[k];
                            r_vy[k] <= in_y[k];
                        end
                        r_color  <= i_color;
                        r_minx   <= min3(in_x[0], in_x[1], in_x[2]);
                        r_miny   <= min3(in_y[0], in_y[1], in_y[2]);
                        r_maxx   <= max3(in_x[0], in_x[1], in_x[2]);
                        r_maxy   <= max3(in_y[0], in_y[1], in_y[2]);
                        r_px     <= min3(in_x[0], in_x[1], in_x[2]);
                        r_py     <= min3(in_y[0], in_y[1], in_y[2]);
                        r_active <= 1'b0;
                        r_state  <= S_MUL;
                    end else if (pop_step) begin
                        r_ovalid <= 1'b1;
                        r_ox     <= r_px;
                        r_oy     <= r_py;
                        r_ocov   <= covered;
                        r_ocolor <= r_color;
                        r_olast  <= last;
                        if (last) begin
                            r_active <= 1'b0;
                        end else if (r_px == r_maxx) begin
                            r_px <= r_minx;
                            r_py <= r_py + C'(1);
                            for (int k = 0; k < 3; k++) begin
                                r_w[k]    <= r_wrow[k] + E'(r_dy[k]);
                                r_wrow[k] <= r_wrow[k] + E'(r_dy[k]);
                            end
                        end else begin
                            r_px <= r_px + C'(1);
                            for (int k = 0; k < 3; k++) begin
                                r_w[k] <= r_w[k] + E'(r_dx[k]);
                            end
                        end
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < 3; k++) begin
                        r_p0[k] <= P'(ka[k]) * P'(dya[k]);
                        r_p1[k] <= P'(kb[k]) * P'(dxa[k]);
                        r_dx[k] <= dya[k];
                        r_dy[k] <= -dxa[k];
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    for (int k = 0; k < 3; k++) begin
                        r_w[k]    <= E'(r_p0[k]) - E'(r_p1[k]);
                        r_wrow[k] <= E'(r_p0[k]) - E'(r_p1[k]);
                    end
                    r_active <= 1'b1;
                    r_state  <= S_SCAN;
                end
                default: begin
                    r_state <= S_SCAN;
                end
            endcase
        end
    end

    a_setup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> !o_cmd_ready)
        else $error("command taken during triangle setup");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_step && last) |=> (!r_active && r_ovalid && r_olast))
        else $error("scan did not end after the last pixel");

    a_x_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_px >= r_minx && r_px <= r_maxx && r_py <= r_maxy))
        else $error("scan position left the bounding box");

    a_sum_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_SUM))
        else $error("setup sequence broken");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_ox) && $stable(r_oy)))
        else $error("stalled pixel word was overwritten");

endmodule
`default_nettype wire

/* design/triangle_coverage_rasterizer.sv */
// Top level of the triangle coverage rasterizer: input queue front end and scan back end.
// With a triangle loaded, step words give one pixel per clock unless the output stalls.
// A load word occupies the scan engine for setup: store and box, products, sums.
// The two-word input queue lets loads and steps be accepted while the output stalls.
// Reset empties the queue, drops any pending pixel word and leaves no triangle loaded.
`default_nettype none
module triangle_coverage_rasterizer
    import tcr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // action
    input  wire logic                i_s_axis_tuser,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, fill_color
    input  wire logic [((6*COORD_BITS+COLOR_BITS)+7)/8*8-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [((2*COORD_BITS+COLOR_BITS)+7)/8*8-1:0] o_m_axis_tdata,
    // covered
    output logic                     o_m_axis_tuser,
    // last_pixel
    output logic                     o_m_axis_tlast
);

    localparam int C   = COORD_BITS;
    localparam int COL = COLOR_BITS;
    localparam int OW  = ((2*C+COL)+7)/8*8;

    t_cmd_ctl               cmd_ctl;
    logic                   cmd_ready;
    logic      [6*C-1:0]    cmd_vert;
    logic      [COL-1:0]    cmd_color;
    logic signed [C-1:0]    px;
    logic signed [C-1:0]    py;
    logic      [COL-1:0]    pcolor;

    tcr_front #(.C(C), .COL(COL)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_vert      (i_s_axis_tdata[6*C-1:0]),
        .i_color     (i_s_axis_tdata[6*C+COL-1:6*C]),
        .o_ctl       (cmd_ctl),
        .i_cmd_ready (cmd_ready),
        .o_vert      (cmd_vert),
        .o_color     (cmd_color)
    );

    tcr_back #(.C(C), .COL(COL)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (cmd_ctl),
        .o_cmd_ready (cmd_ready),
        .i_vert      (cmd_vert),
        .i_color     (cmd_color),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_x         (px),
        .o_y         (py),
        .o_covered   (o_m_axis_tuser),
        .o_color     (pcolor),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OW'({pcolor, py, px});

endmodule
`default_nettype wire
